@@ sv/srsw_pkg.sv @@
// Package: shared constants and types for the selective-repeat sender window.
package srsw_pkg;
    localparam int NUM_RECEIVERS = 8;
    localparam int WINDOW_SLOTS  = 8;
    localparam int SEQ_COUNT     = 16;
    localparam int RCV_W         = 3;
    localparam int SLOT_W        = 3;
    localparam int IDX_W         = RCV_W + SLOT_W;
    localparam int NUM_ENTRIES   = 1 << IDX_W;
    localparam int SEQ_W         = 4;
    localparam int TAG_W         = 16;
    localparam int TMR_W         = 20;
    localparam int ID_W          = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd1;

    localparam logic [1:0] CMD_SEND  = 2'd0;
    localparam logic [1:0] CMD_REPLY = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    localparam logic [1:0] RK_ACK = 2'd1;
    localparam logic [1:0] RK_NAK = 2'd2;

    localparam logic [2:0] K_SENT    = 3'd0;
    localparam logic [2:0] K_FULL    = 3'd1;
    localparam logic [2:0] K_IGNORED = 3'd2;
    localparam logic [2:0] K_ACK     = 3'd3;
    localparam logic [2:0] K_NAK     = 3'd4;
    localparam logic [2:0] K_RETX    = 3'd5;
    localparam logic [2:0] K_NONE    = 3'd6;

    typedef struct packed {
        logic [2:0]       kind;
        logic [RCV_W-1:0] rcv;
        logic [SEQ_W-1:0] seq;
        logic [TAG_W-1:0] tag;
        logic [SEQ_W-1:0] base;
        logic             last;
    } t_result;
endpackage

@@ sv/srsw_out_reg.sv @@
// Output register stage holding one result beat toward the consumer.
module srsw_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  srsw_pkg::t_result i_res,
    output logic              o_full,
    input  logic              i_take,
    output srsw_pkg::t_result o_res
);
    logic              r_full;
    srsw_pkg::t_result r_res;

    // hold one beat until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= 1'b0;
        end else if (i_load) begin
            r_full <= 1'b1;
        end else if (i_take) begin
            r_full <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_full = r_full;
    assign o_res  = r_res;
endmodule

@@ sv/selective_repeat_sender_window.sv @@
// Top level: selective-repeat ARQ sender with one window per receiver.
// Send, NAK and ignored reply: S_FIND or S_REPLY decodes the latched input; u_out registers it.
// ACK: the result follows S_SLIDE, which latches the slide amount and, if any, reads then moves
//   each of the 8 slots in turn, then S_EMIT. Tick: reads and checks each of the 64 slots, then
//   S_TFIN flushes the final beat; the scan stalls while a result beat waits.
// Input not ready while busy or a result waits; sync active-low reset clears flags and bases.
module selective_repeat_sender_window (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [srsw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [srsw_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_cmd,
    input  logic [2:0]                       i_receiver,
    input  logic [7:0]                       i_reply_dest,
    input  logic [3:0]                       i_reply_seq,
    input  logic [1:0]                       i_reply_kind,
    input  logic                             i_crc_ok,
    input  logic [15:0]                      i_payload_tag,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [2:0]                       o_kind,
    output logic [2:0]                       o_out_receiver,
    output logic [3:0]                       o_out_seq,
    output logic [15:0]                      o_out_tag,
    output logic [3:0]                       o_window_base,
    output logic                             o_last
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FIND  = 3'd1;
    localparam logic [2:0] S_REPLY = 3'd2;
    localparam logic [2:0] S_SLIDE = 3'd3;
    localparam logic [2:0] S_TICK  = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;
    localparam logic [2:0] S_TFIN  = 3'd6;

    // configuration
    logic [srsw_pkg::ID_W-1:0]  r_own_id;
    logic [srsw_pkg::TMR_W-1:0] r_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id  <= '0;
            r_timeout <= srsw_pkg::TMR_W'(100);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                srsw_pkg::CFG_OWN_ID:  r_own_id  <= i_cfg_data[srsw_pkg::ID_W-1:0];
                srsw_pkg::CFG_TIMEOUT: r_timeout <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // per-slot flags and bases in flip-flops
    logic [srsw_pkg::NUM_ENTRIES-1:0] r_sent, r_acked;
    logic [srsw_pkg::SEQ_W-1:0]       r_base [srsw_pkg::NUM_RECEIVERS];
    // tags and timers in memories
    logic [srsw_pkg::TAG_W-1:0]       m_tag  [srsw_pkg::NUM_ENTRIES];
    logic [srsw_pkg::TMR_W-1:0]       m_tmr  [srsw_pkg::NUM_ENTRIES];

    logic [2:0]                  r_state;
    logic [srsw_pkg::RCV_W-1:0]  r_rcv;
    logic [srsw_pkg::SEQ_W-1:0]  r_rseq;
    logic [1:0]                  r_rkind;
    logic                        r_match;
    logic [srsw_pkg::TAG_W-1:0]  r_tag_in;
    logic [srsw_pkg::IDX_W-1:0]  r_idx;   // scan / slide index
    logic [srsw_pkg::SLOT_W:0]   r_k;     // slide amount
    logic                        r_any;   // a retransmit beat is held in r_pend
    logic                        r_rd_ok; // memory read data valid for w_raddr
    logic [srsw_pkg::TAG_W-1:0]  r_tag_q;
    logic [srsw_pkg::TMR_W-1:0]  r_tmr_q;
    srsw_pkg::t_result           r_pend;  // latest retransmit beat of a tick

    logic              w_load, w_full, w_take;
    srsw_pkg::t_result w_res, w_out;

    srsw_out_reg u_out (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_load (w_load),
        .i_res  (w_res),
        .o_full (w_full),
        .i_take (w_take),
        .o_res  (w_out)
    );

    assign w_take  = o_valid && i_ready;
    assign o_valid = w_full;
    assign o_kind         = w_out.kind;
    assign o_out_receiver = w_out.rcv;
    assign o_out_seq      = w_out.seq;
    assign o_out_tag      = w_out.tag;
    assign o_window_base  = w_out.base;
    assign o_last         = w_out.last;
    assign o_ready = (r_state == S_IDLE) && !w_full;

    // helpers on the current receiver's window
    logic [srsw_pkg::SLOT_W-1:0] w_free;
    logic                        w_has_free;
    logic [srsw_pkg::SLOT_W:0]   w_lead;
    logic [srsw_pkg::SEQ_W-1:0]  w_off;
    logic [srsw_pkg::WINDOW_SLOTS-1:0] w_ws, w_wa;
    logic [srsw_pkg::IDX_W-1:0]  w_ridx;
    logic                        w_lead_done;

    assign w_ws  = r_sent[{r_rcv, 3'd0} +: srsw_pkg::WINDOW_SLOTS];
    assign w_wa  = r_acked[{r_rcv, 3'd0} +: srsw_pkg::WINDOW_SLOTS];
    assign w_off = r_rseq - r_base[r_rcv];
    assign w_ridx = {r_rcv, w_off[srsw_pkg::SLOT_W-1:0]};

    always_comb begin
        w_free      = '0;
        w_has_free  = 1'b0;
        w_lead      = '0;
        w_lead_done = 1'b0;
        for (int i = srsw_pkg::WINDOW_SLOTS - 1; i >= 0; i--) begin
            if (!w_ws[i]) begin
                w_free     = srsw_pkg::SLOT_W'(i);
                w_has_free = 1'b1;
            end
        end
        for (int i = 0; i < srsw_pkg::WINDOW_SLOTS; i++) begin
            if (!w_lead_done && w_ws[i] && w_wa[i]) begin
                w_lead = w_lead + 1'b1;
            end else begin
                w_lead_done = 1'b1;
            end
        end
    end

    // slide source index and its validity
    logic [srsw_pkg::SLOT_W:0]   w_src;
    logic                        w_src_in;
    assign w_src    = {1'b0, r_idx[srsw_pkg::SLOT_W-1:0]} + r_k;
    assign w_src_in = !w_src[srsw_pkg::SLOT_W];

    // memory read address per state
    logic [srsw_pkg::IDX_W-1:0] w_raddr;
    always_comb begin
        w_raddr = r_idx;
        if (r_state == S_SLIDE) begin
            w_raddr = {r_rcv, w_src[srsw_pkg::SLOT_W-1:0]};
        end
    end

    // registered memory reads
    always_ff @(posedge i_clk) begin
        r_tag_q <= m_tag[w_raddr];
        r_tmr_q <= m_tmr[w_raddr];
    end

    logic                       w_we;
    logic [srsw_pkg::IDX_W-1:0] w_waddr;
    logic [srsw_pkg::TAG_W-1:0] w_wtag;
    logic [srsw_pkg::TMR_W-1:0] w_wtmr;
    logic                       w_wtag_en;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            m_tmr[w_waddr] <= w_wtmr;
            if (w_wtag_en) begin
                m_tag[w_waddr] <= w_wtag;
            end
        end
    end

    logic [srsw_pkg::SEQ_W-1:0] w_tick_base;
    logic                       w_tick_live;
    assign w_tick_base = r_base[r_idx[srsw_pkg::IDX_W-1:srsw_pkg::SLOT_W]];
    assign w_tick_live = r_sent[r_idx] && !r_acked[r_idx];

    // retransmit beat for the slot under scan
    srsw_pkg::t_result w_tick_res;
    always_comb begin
        w_tick_res      = '0;
        w_tick_res.kind = srsw_pkg::K_RETX;
        w_tick_res.rcv  = r_idx[srsw_pkg::IDX_W-1:srsw_pkg::SLOT_W];
        w_tick_res.seq  = w_tick_base + srsw_pkg::SEQ_W'(r_idx[srsw_pkg::SLOT_W-1:0]);
        w_tick_res.tag  = r_tag_q;
        w_tick_res.base = w_tick_base;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sent  <= '0;
            r_acked <= '0;
            r_rd_ok <= 1'b0;
            for (int i = 0; i < srsw_pkg::NUM_RECEIVERS; i++) begin
                r_base[i] <= '0;
            end
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_rcv    <= i_receiver;
                        r_rseq   <= i_reply_seq;
                        r_rkind  <= i_reply_kind;
                        r_match  <= i_crc_ok && (i_reply_dest == r_own_id);
                        r_tag_in <= i_payload_tag;
                        r_idx    <= '0;
                        r_any    <= 1'b0;
                        r_rd_ok  <= 1'b0;
                        unique case (i_cmd)
                            srsw_pkg::CMD_SEND:  r_state <= S_FIND;
                            srsw_pkg::CMD_REPLY: r_state <= S_REPLY;
                            srsw_pkg::CMD_TICK:  r_state <= S_TICK;
                            default:             r_state <= S_IDLE;
                        endcase
                    end
                end
                S_FIND: begin
                    if (w_has_free) begin
                        r_sent[{r_rcv, w_free}]  <= 1'b1;
                        r_acked[{r_rcv, w_free}] <= 1'b0;
                    end
                    r_state <= S_IDLE;
                end
                S_REPLY: begin
                    if (r_match && !w_off[srsw_pkg::SEQ_W-1] && r_sent[w_ridx]) begin
                        if (r_rkind == srsw_pkg::RK_ACK) begin
                            r_acked[w_ridx] <= 1'b1;
                            r_state <= S_SLIDE;
                            r_idx   <= {r_rcv, 3'd0};
                            r_k     <= '0;
                            r_rd_ok <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SLIDE: begin
                    // first latch slide amount (none: go to S_EMIT); then read and move each slot in turn
                    if (!r_rd_ok && r_k == '0) begin
                        if (w_lead == '0) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_k     <= w_lead;
                            r_rd_ok <= 1'b0;
                        end
                    end else if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else begin
                        if (w_src_in) begin
                            r_sent[r_idx]  <= r_sent[{r_rcv, w_src[srsw_pkg::SLOT_W-1:0]}];
                            r_acked[r_idx] <= r_acked[{r_rcv, w_src[srsw_pkg::SLOT_W-1:0]}];
                        end else begin
                            r_sent[r_idx]  <= 1'b0;
                            r_acked[r_idx] <= 1'b0;
                        end
                        r_rd_ok <= 1'b0;
                        if (r_idx[srsw_pkg::SLOT_W-1:0] ==
                            srsw_pkg::SLOT_W'(srsw_pkg::WINDOW_SLOTS-1)) begin
                            r_base[r_rcv] <= r_base[r_rcv] + srsw_pkg::SEQ_W'(r_k);
                            r_state <= S_EMIT;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_TICK: begin
                    if (!r_rd_ok) begin
                        r_rd_ok <= 1'b1;
                    end else if (!w_full) begin
                        r_rd_ok <= 1'b0;
                        // hold the newest retransmit until the next one or the scan end
                        if (w_tick_live && r_tmr_q <= srsw_pkg::TMR_W'(1)) begin
                            r_any  <= 1'b1;
                            r_pend <= w_tick_res;
                        end
                        if (r_idx == srsw_pkg::IDX_W'(srsw_pkg::NUM_ENTRIES-1)) begin
                            r_state <= S_TFIN;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                S_TFIN: begin
                    if (!w_full) begin
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // memory writes and result beats
    logic w_fire_tick;
    assign w_fire_tick = (r_state == S_TICK) && r_rd_ok && !w_full && w_tick_live
                         && (r_tmr_q <= srsw_pkg::TMR_W'(1));

    always_comb begin
        w_we      = 1'b0;
        w_waddr   = r_idx;
        w_wtag    = r_tag_q;
        w_wtmr    = r_tmr_q;
        w_wtag_en = 1'b0;
        w_load    = 1'b0;
        w_res     = '0;
        w_res.rcv = r_rcv;
        w_res.last = 1'b1;
        case (r_state)
            S_FIND: begin
                w_load = 1'b1;
                if (w_has_free) begin
                    w_we      = 1'b1;
                    w_waddr   = {r_rcv, w_free};
                    w_wtag    = r_tag_in;
                    w_wtag_en = 1'b1;
                    w_wtmr    = r_timeout;
                    w_res.kind = srsw_pkg::K_SENT;
                    w_res.seq  = r_base[r_rcv] + srsw_pkg::SEQ_W'(w_free);
                    w_res.tag  = r_tag_in;
                    w_res.base = r_base[r_rcv];
                end else begin
                    w_res.kind = srsw_pkg::K_FULL;
                    w_res.base = r_base[r_rcv];
                end
            end
            S_REPLY: begin
                w_res.seq  = r_rseq;
                w_res.base = r_base[r_rcv];
                w_res.kind = srsw_pkg::K_IGNORED;
                if (r_match && !w_off[srsw_pkg::SEQ_W-1] && r_sent[w_ridx]) begin
                    if (r_rkind == srsw_pkg::RK_NAK) begin
                        w_we    = 1'b1;
                        w_waddr = w_ridx;
                        w_wtmr  = '0;
                        w_res.kind = srsw_pkg::K_NAK;
                        w_load  = 1'b1;
                    end else if (r_rkind != srsw_pkg::RK_ACK) begin
                        w_load = 1'b1;
                    end
                end else begin
                    w_load = 1'b1;
                end
            end
            S_SLIDE: begin
                if (r_rd_ok) begin
                    w_we      = 1'b1;
                    w_waddr   = r_idx;
                    w_wtag_en = 1'b1;
                    w_wtag    = w_src_in ? r_tag_q : '0;
                    w_wtmr    = w_src_in ? r_tmr_q : '0;
                end
            end
            S_EMIT: begin
                w_load     = 1'b1;
                w_res.kind = srsw_pkg::K_ACK;
                w_res.seq  = r_rseq;
                w_res.base = r_base[r_rcv];
            end
            S_TICK: begin
                if (r_rd_ok && !w_full && w_tick_live) begin
                    w_we   = 1'b1;
                    w_wtmr = (r_tmr_q <= srsw_pkg::TMR_W'(1)) ? r_timeout
                                                              : r_tmr_q - 1'b1;
                end
                // release the held retransmit once a newer one is found
                if (w_fire_tick && r_any) begin
                    w_load = 1'b1;
                    w_res  = r_pend;
                end
            end
            S_TFIN: begin
                // final beat of the tick: held retransmit, or no timeout
                if (!w_full) begin
                    w_load = 1'b1;
                    if (r_any) begin
                        w_res      = r_pend;
                        w_res.last = 1'b1;
                    end else begin
                        w_res.kind = srsw_pkg::K_NONE;
                        w_res.rcv  = '0;
                        w_res.last = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready)
        else $error("input accepted while busy");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !w_full || w_take || (r_state != S_TICK))
        else $error("result overwritten");
    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_kind <= srsw_pkg::K_NONE))
        else $error("bad result kind");
`endif
endmodule
